FILE: hdl/rmts_pkg.sv
package rmts_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN_RD,
        ST_SCAN,
        ST_RUN,
        ST_DONE
    } state_t;

    // controller -> datapath commands
    typedef struct packed {
        logic do_write;
        logic scan_clear;
        logic scan_step;
        logic run_apply;
        logic tick_adv;
        logic emit;
    } dp_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic scan_last;
    } dp_sts_t;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

endpackage

FILE: hdl/rmts_ctrl.sv
module rmts_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              cmd,
    input  rmts_pkg::dp_sts_t sts,
    output rmts_pkg::dp_cmd_t ctl,
    output logic              busy
);

    rmts_pkg::state_t state_reg;
    rmts_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rmts_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (cmd == rmts_pkg::CMD_WRITE) ? rmts_pkg::ST_WRITE
                                                              : rmts_pkg::ST_SCAN_RD;
                end
            end
            rmts_pkg::ST_WRITE:   state_next = rmts_pkg::ST_DONE;
            rmts_pkg::ST_SCAN_RD: state_next = rmts_pkg::ST_SCAN;
            rmts_pkg::ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = rmts_pkg::ST_RUN;
                end
            end
            rmts_pkg::ST_RUN:     state_next = rmts_pkg::ST_DONE;
            rmts_pkg::ST_DONE:    state_next = rmts_pkg::ST_IDLE;
            default:              state_next = rmts_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctl  = '0;
        busy = (state_reg != rmts_pkg::ST_IDLE);
        unique case (state_reg)
            rmts_pkg::ST_IDLE:    ctl.scan_clear = 1'b1;
            rmts_pkg::ST_WRITE:   ctl.do_write = 1'b1;
            rmts_pkg::ST_SCAN_RD: ctl.scan_clear = 1'b0;
            rmts_pkg::ST_SCAN:    ctl.scan_step = 1'b1;
            rmts_pkg::ST_RUN:
            begin
                ctl.run_apply = 1'b1;
                ctl.tick_adv  = 1'b1;
            end
            rmts_pkg::ST_DONE:    ctl.emit = 1'b1;
            default:              ctl = '0;
        endcase
    end

endmodule

FILE: hdl/rmts_dp.sv
module rmts_dp #(
    parameter int TASKS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start_acc,
    input  logic [3:0]        task_index,
    input  logic [15:0]       period,
    input  logic [15:0]       exec_time,
    input  logic [15:0]       first_release,
    input  rmts_pkg::dp_cmd_t ctl,
    output rmts_pkg::dp_sts_t sts,
    output logic              done,
    output logic              run_valid,
    output logic [3:0]        run_task,
    output logic              job_done,
    output logic [4:0]        misses_now,
    output logic [15:0]       miss_total,
    output logic [31:0]       time_now
);

    localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;

    // per-slot table, each entry updated only at its own index
    logic [TASKS-1:0] used_reg;
    logic [15:0]      per_reg  [TASKS];
    logic [15:0]      exe_reg  [TASKS];
    logic [31:0]      rel_reg  [TASKS];
    logic [31:0]      dl_reg   [TASKS];
    logic [15:0]      work_reg [TASKS];

    // latched write beat
    logic [3:0]  widx_reg;
    logic [15:0] wper_reg, wexe_reg, wfr_reg;
    logic [IW-1:0] widx;

    logic [31:0] tick_reg;
    logic [15:0] sum_reg;
    logic [IW-1:0] scan_reg;
    logic [4:0]  miss_reg;
    logic        best_v_reg;
    logic [IW-1:0] best_reg;
    logic [15:0] bper_reg;
    logic [15:0] bwork_reg;

    // scanned slot: miss then release, evaluated for one slot per cycle
    logic [15:0] cur_work;
    logic        cur_miss;
    logic        cur_rel;
    logic [15:0] new_work;

    always_comb
    begin
        cur_work = work_reg[scan_reg];
        cur_miss = used_reg[scan_reg] && (cur_work != 16'd0) && (dl_reg[scan_reg] <= tick_reg);
        cur_rel  = used_reg[scan_reg] && (rel_reg[scan_reg] == tick_reg);
        new_work = cur_rel ? exe_reg[scan_reg] : (cur_miss ? 16'd0 : cur_work);
    end

    assign sts.scan_last = (scan_reg == IW'(TASKS - 1));

    // table index of the latched write slot
    assign widx = IW'(widx_reg);

    always_ff @(posedge clk)
    begin
        if (start_acc)
        begin
            widx_reg <= task_index;
            wper_reg <= period;
            wexe_reg <= exec_time;
            wfr_reg  <= first_release;
        end
    end

    // table and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            for (int i = 0; i < TASKS; i++)
            begin
                work_reg[i] <= 16'd0;
            end
            tick_reg   <= 32'd0;
            sum_reg    <= 16'd0;
            scan_reg   <= '0;
            miss_reg   <= 5'd0;
            best_v_reg <= 1'b0;
            best_reg   <= '0;
            bper_reg   <= 16'd0;
            bwork_reg  <= 16'd0;
        end
        else
        begin
            if (ctl.do_write && (32'(widx_reg) < TASKS))
            begin
                used_reg[widx] <= 1'b1;
                per_reg[widx]  <= wper_reg;
                exe_reg[widx]  <= wexe_reg;
                rel_reg[widx]  <= {16'd0, wfr_reg};
                dl_reg[widx]   <= {16'd0, wfr_reg} + {16'd0, wper_reg};
                work_reg[widx] <= 16'd0;
            end
            if (ctl.scan_clear)
            begin
                scan_reg   <= '0;
                miss_reg   <= 5'd0;
                best_v_reg <= 1'b0;
            end
            if (ctl.scan_step)
            begin
                work_reg[scan_reg] <= new_work;
                if (cur_rel)
                begin
                    dl_reg[scan_reg]  <= tick_reg + {16'd0, per_reg[scan_reg]};
                    rel_reg[scan_reg] <= rel_reg[scan_reg] + {16'd0, per_reg[scan_reg]};
                end
                if (cur_miss)
                begin
                    if (miss_reg != 5'd31)
                    begin
                        miss_reg <= miss_reg + 5'd1;
                    end
                    if (sum_reg != 16'hFFFF)
                    begin
                        sum_reg <= sum_reg + 16'd1;
                    end
                end
                // strict less keeps the lower index on ties
                if (used_reg[scan_reg] && (new_work != 16'd0) &&
                    (!best_v_reg || (per_reg[scan_reg] < bper_reg)))
                begin
                    best_v_reg <= 1'b1;
                    best_reg   <= scan_reg;
                    bper_reg   <= per_reg[scan_reg];
                    bwork_reg  <= new_work;
                end
                if (!sts.scan_last)
                begin
                    scan_reg <= scan_reg + IW'(1);
                end
            end
            if (ctl.run_apply && best_v_reg)
            begin
                work_reg[best_reg] <= bwork_reg - 16'd1;
            end
            if (ctl.tick_adv)
            begin
                tick_reg <= tick_reg + 32'd1;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done       <= 1'b0;
            run_valid  <= 1'b0;
            run_task   <= 4'd0;
            job_done   <= 1'b0;
            misses_now <= 5'd0;
            miss_total <= 16'd0;
            time_now   <= 32'd0;
        end
        else
        begin
            done <= 1'b0;
            if (ctl.do_write)
            begin
                run_valid  <= 1'b0;
                run_task   <= 4'd0;
                job_done   <= 1'b0;
                misses_now <= 5'd0;
                time_now   <= tick_reg;
            end
            if (ctl.run_apply)
            begin
                run_valid  <= best_v_reg;
                run_task   <= best_v_reg ? 4'(best_reg) : 4'd0;
                job_done   <= best_v_reg && (bwork_reg == 16'd1);
                misses_now <= miss_reg;
                time_now   <= tick_reg;
            end
            if (ctl.emit)
            begin
                done       <= 1'b1;
                miss_total <= sum_reg;
            end
        end
    end

endmodule

FILE: hdl/rate_monotonic_tick_scheduler.sv
// Channel  | Signals                                            | Beat taken when
// ---------+----------------------------------------------------+-----------------------
// command  | start, cmd, task_index, period, exec_time,         | start && !busy
//          | first_release                                      |
// result   | done, run_valid, run_task, job_done, misses_now,   | done high (one cycle)
//          | miss_total, time_now                               |
//
// A write beat passes ST_WRITE and ST_DONE; a tick beat passes ST_SCAN_RD, ST_SCAN
// (a serial scan of one task slot per cycle), ST_RUN and ST_DONE; done is registered.
// busy stays high from the accepted beat until done rises; the next beat can be
// taken in the cycle that shows done.
// rst_n clears slot-used flags, pending work, the tick counter and the miss total.
// The receiver cannot stall; each result is shown for exactly one cycle.
module rate_monotonic_tick_scheduler #(
    parameter int TASKS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [3:0]  task_index,
    input  logic [15:0] period,
    input  logic [15:0] exec_time,
    input  logic [15:0] first_release,
    output logic        done,
    output logic        run_valid,
    output logic [3:0]  run_task,
    output logic        job_done,
    output logic [4:0]  misses_now,
    output logic [15:0] miss_total,
    output logic [31:0] time_now
);

    rmts_pkg::dp_cmd_t ctl;
    rmts_pkg::dp_sts_t sts;
    logic              start_acc;

    assign start_acc = start && !busy;

    rmts_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_acc),
        .cmd   (cmd),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    rmts_dp #(
        .TASKS (TASKS)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start_acc     (start_acc),
        .task_index    (task_index),
        .period        (period),
        .exec_time     (exec_time),
        .first_release (first_release),
        .ctl           (ctl),
        .sts           (sts),
        .done          (done),
        .run_valid     (run_valid),
        .run_task      (run_task),
        .job_done      (job_done),
        .misses_now    (misses_now),
        .miss_total    (miss_total),
        .time_now      (time_now)
    );

    // a result shows up once the block is free again
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while a beat is still in flight");

    // each result is shown for a single cycle
    a_free_after: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result held longer than one cycle");

    // idle results never report a finished job
    a_done_run: assert property (@(posedge clk) disable iff (!rst_n)
        (done && job_done) |-> run_valid)
        else $error("job_done without a running task");

endmodule

FILE: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTASK = 16;

    typedef struct packed {
        logic        op;
        logic [3:0]  slot;
        logic [15:0] per;
        logic [15:0] wcet;
        logic [15:0] rel;
    } sched_beat_t;

    typedef struct packed {
        logic        ran;
        logic [3:0]  who;
        logic        fin;
        logic [4:0]  nmiss;
        logic [15:0] msum;
        logic [31:0] tick;
    } sched_out_t;

    typedef bit  bool_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cmd;
    logic [3:0]  task_index;
    logic [15:0] period;
    logic [15:0] exec_time;
    logic [15:0] first_release;
    logic        done;
    logic        run_valid;
    logic [3:0]  run_task;
    logic        job_done;
    logic [4:0]  misses_now;
    logic [15:0] miss_total;
    logic [31:0] time_now;

    rate_monotonic_tick_scheduler dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .task_index(task_index), .period(period), .exec_time(exec_time),
        .first_release(first_release), .done(done), .run_valid(run_valid),
        .run_task(run_task), .job_done(job_done), .misses_now(misses_now),
        .miss_total(miss_total), .time_now(time_now)
    );

    // scheduler shadow state
    logic        used_q [NTASK];
    logic [15:0] per_q [NTASK];
    logic [15:0] wcet_q [NTASK];
    logic [31:0] nrel_q [NTASK];
    logic [31:0] dl_q [NTASK];
    logic [15:0] left_q [NTASK];
    logic [31:0] tick_q;
    logic [15:0] msum_q;

    sched_beat_t pending_beats[$];
    sched_out_t  expected_runs[$];
    int          errors = 0;
    int          beats_sent = 0;
    int          results_seen = 0;
    int          runs_seen = 0;
    int          misses_seen = 0;
    bool_t       quiet;

    // compute one scheduler decision and update shadow state
    function automatic sched_out_t schedule_beat(sched_beat_t b);
        sched_out_t r;
        int best;
        int nm;
        r = '0;
        best = -1;
        nm = 0;
        r.tick = tick_q;
        if (b.op == rmts_pkg::CMD_WRITE) begin
            used_q[b.slot] = 1'b1;
            per_q[b.slot]  = b.per;
            wcet_q[b.slot] = b.wcet;
            nrel_q[b.slot] = {16'd0, b.rel};
            dl_q[b.slot]   = {16'd0, b.rel} + {16'd0, b.per};
            left_q[b.slot] = '0;
        end else begin
            // deadline misses before release
            for (int i = 0; i < NTASK; i++)
                if (used_q[i] && left_q[i] != 0 && dl_q[i] <= tick_q) begin
                    left_q[i] = '0;
                    nm++;
                    if (msum_q != 16'hFFFF) msum_q++;
                end
            for (int i = 0; i < NTASK; i++)
                if (used_q[i] && nrel_q[i] == tick_q) begin
                    left_q[i] = wcet_q[i];
                    dl_q[i]   = tick_q + {16'd0, per_q[i]};
                    nrel_q[i] = nrel_q[i] + {16'd0, per_q[i]};
                end
            for (int i = 0; i < NTASK; i++)
                if (used_q[i] && left_q[i] != 0)
                    if (best < 0 || per_q[i] < per_q[best]) best = i;
            if (best >= 0) begin
                r.ran = 1'b1;
                r.who = best[3:0];
                left_q[best] = left_q[best] - 16'd1;
                r.fin = (left_q[best] == 0);
            end
            tick_q = tick_q + 32'd1;
        end
        r.nmiss = (nm > 31) ? 5'd31 : nm[4:0];
        r.msum  = msum_q;
        return r;
    endfunction

    function automatic sched_beat_t make_write(int s, int p, int e, int f);
        sched_beat_t b;
        b.op = rmts_pkg::CMD_WRITE;
        b.slot = s[3:0];
        b.per = p[15:0];
        b.wcet = e[15:0];
        b.rel = f[15:0];
        return b;
    endfunction

    function automatic sched_beat_t make_tick();
        sched_beat_t b;
        b.op = rmts_pkg::CMD_TICK;
        b.slot = 4'($urandom);
        b.per = 16'($urandom);
        b.wcet = 16'($urandom);
        b.rel = 16'($urandom);
        return b;
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // driver: one beat per handshake, random gaps outside the quiet stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= rmts_pkg::CMD_WRITE;
            task_index <= '0;
            period <= '0;
            exec_time <= '0;
            first_release <= '0;
        end
        else if (!start || !busy)
        begin
            // either nothing was offered or the offered beat was just taken
            if (start)
            begin
                expected_runs.push_back(schedule_beat(pending_beats.pop_front()));
                beats_sent++;
            end
            if (pending_beats.size() != 0 && (quiet || $urandom_range(99) >= 19))
            begin
                start <= 1'b1;
                cmd <= pending_beats[0].op;
                task_index <= pending_beats[0].slot;
                period <= pending_beats[0].per;
                exec_time <= pending_beats[0].wcet;
                first_release <= pending_beats[0].rel;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        sched_out_t exp_r;
        sched_out_t got;
        if (rst_n && done)
        begin
            got = {run_valid, run_task, job_done, misses_now, miss_total, time_now};
            results_seen++;
            if (run_valid) runs_seen++;
            if (misses_now != 0) misses_seen++;
            if (expected_runs.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
            end
            else
            begin
                exp_r = expected_runs.pop_front();
                if (got.ran !== exp_r.ran || got.who !== exp_r.who
                    || got.fin !== exp_r.fin || got.nmiss !== exp_r.nmiss
                    || got.msum !== exp_r.msum || got.tick !== exp_r.tick)
                begin
                    errors++;
                    $display("%0t: exp run=%b task=%0d done=%b miss=%0d tot=%0d t=%0d",
                        $time, exp_r.ran, exp_r.who, exp_r.fin, exp_r.nmiss,
                        exp_r.msum, exp_r.tick);
                    $display("%0t: got run=%b task=%0d done=%b miss=%0d tot=%0d t=%0d",
                        $time, got.ran, got.who, got.fin, got.nmiss, got.msum, got.tick);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int total;
        int n;
        for (int i = 0; i < NTASK; i++)
        begin
            used_q[i] = 0; per_q[i] = 0; wcet_q[i] = 0;
            nrel_q[i] = 0; dl_q[i] = 0; left_q[i] = 0;
        end
        tick_q = 0;
        msum_q = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: idle tick, extremes, zero period, zero work, ties, misses
        pending_beats.push_back(make_tick());
        pending_beats.push_back(make_write(15, 65535, 65535, 65535));
        pending_beats.push_back(make_write(0, 1, 0, 0));
        pending_beats.push_back(make_write(3, 0, 3, 2));
        pending_beats.push_back(make_write(5, 4, 2, 1));
        pending_beats.push_back(make_write(6, 4, 2, 1));
        pending_beats.push_back(make_write(7, 2, 3, 3));
        pending_beats.push_back(make_write(9, 3, 3, 0));
        for (int k = 0; k < 14; k++) pending_beats.push_back(make_tick());
        pending_beats.push_back(make_write(15, 1, 1, 0));

        // random: mostly ticks over small task sets, occasional rewrites
        total = 1800;
        n = pending_beats.size();
        while (n < total)
        begin
            if ($urandom_range(99) < 12)
            begin
                case ($urandom_range(3))
                    0: pending_beats.push_back(make_write($urandom_range(15),
                        $urandom, $urandom, $urandom));
                    default: pending_beats.push_back(make_write($urandom_range(15),
                        $urandom_range(1, 12), $urandom_range(0, 5),
                        tick_q + $urandom_range(0, 40) + n / 2));
                endcase
            end
            else
                pending_beats.push_back(make_tick());
            n++;
        end

        // long stretch without gaps partway through
        wait (beats_sent >= 700);
        quiet = 1'b1;
        wait (beats_sent >= 1100);
        quiet = 1'b0;
        wait (pending_beats.size() == 0 && !start);
        wait (expected_runs.size() == 0);
        repeat (40) @(posedge clk);

        $display("Sent %0d beats; %0d results, %0d with a task running, %0d with misses.",
            beats_sent, results_seen, runs_seen, misses_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
